@@ rtl/crc32b_pkg.sv @@
package crc32b_pkg;

    localparam int CrcWidth  = 32;
    localparam int ByteWidth = 8;
    localparam int CfgWidth  = 32;

    localparam logic [CrcWidth-1:0] CrcPoly     = 32'hEDB8_8320;
    localparam logic [CrcWidth-1:0] StartReset  = 32'h0000_0000;
    localparam logic [CrcWidth-1:0] FinalReset  = 32'h0000_0000;

    typedef enum logic [0:0] {
        CFG_START_VALUE = 1'b0,
        CFG_FINAL_XOR   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic load;
        logic room;
    } out_ctl_t;

    function automatic logic [CrcWidth-1:0] crc_fold_byte(
        input logic [CrcWidth-1:0]  crc,
        input logic [ByteWidth-1:0] data
    );
        logic [CrcWidth-1:0] c;
        c = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
        for (int k = 0; k < ByteWidth; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CrcPoly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/crc32b_fold.sv @@
module crc32b_fold
    import crc32b_pkg::*;
(
    input  logic [CrcWidth-1:0]  running_crc,
    input  logic [CrcWidth-1:0]  start_value,
    input  logic [ByteWidth-1:0] data_byte,
    input  logic                 first_byte,
    output logic [CrcWidth-1:0]  crc_next
);

    logic [CrcWidth-1:0] base;

    always_comb
    begin
        base     = first_byte ? start_value : running_crc;
        crc_next = crc_fold_byte(base, data_byte);
    end

endmodule

@@ rtl/crc32b_out.sv @@
module crc32b_out
    import crc32b_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  out_ctl_t            ctl,
    input  logic [CrcWidth-1:0] crc_in,
    input  logic [CrcWidth-1:0] final_xor,
    output logic                room,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CrcWidth-1:0] crc_value
);

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CrcWidth-1:0] crc_value_reg;
    logic [CrcWidth-1:0] crc_value_next;

    assign room = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        crc_value_next = crc_value_reg;
        if (ctl.load && ctl.room)
        begin
            out_valid_next = 1'b1;
            crc_value_next = crc_in ^ final_xor;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_value_reg <= crc_value_next;
    end

    assign out_valid = out_valid_reg;
    assign crc_value = crc_value_reg;

endmodule

@@ rtl/crc32_byte_stream_core.sv @@
// Byte-serial reflected CRC-32 (polynomial 0xEDB88320). Each beat on the input
// carries one byte with first/last flags; a first byte restarts from
// start_value, and a last byte yields one output beat holding the CRC XORed
// with final_xor. Other bytes produce no output. From input beat to output
// beat a byte passes one input register, then the unrolled eight-bit update
// into the running CRC register and the output register. One byte is taken
// every cycle as long as the output side keeps up; a stalled output only
// holds back a last byte behind it. Write start_value and final_xor through
// the cfg port while no message is in flight; both reset to zero.
module crc32_byte_stream_core
    import crc32b_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ByteWidth-1:0] data_byte,
    input  logic                 first_byte,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CrcWidth-1:0]  crc_value,
    input  logic                 cfg_we,
    input  cfg_index_t           cfg_index,
    input  logic [CfgWidth-1:0]  cfg_data
);

    logic [CrcWidth-1:0]  start_value_reg;
    logic [CrcWidth-1:0]  final_xor_reg;
    logic [CrcWidth-1:0]  crc_reg;
    logic [CrcWidth-1:0]  crc_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [ByteWidth-1:0] s1_data_reg;
    logic                 s1_first_reg;
    logic                 s1_last_reg;

    logic                 s1_go;
    logic                 out_room;
    logic                 in_take;
    out_ctl_t             out_ctl;

    assign s1_go    = s1_valid_reg && (!s1_last_reg || out_room);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    assign out_ctl.load = s1_valid_reg && s1_last_reg;
    assign out_ctl.room = out_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= StartReset;
            final_xor_reg   <= FinalReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_VALUE: start_value_reg <= cfg_data;
                CFG_FINAL_XOR:   final_xor_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            crc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_go)
            begin
                crc_reg <= crc_next;
            end
        end
    end

    // hold the beat until it moves on
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg  <= data_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
        end
    end

    crc32b_fold u_fold (
        .running_crc (crc_reg),
        .start_value (start_value_reg),
        .data_byte   (s1_data_reg),
        .first_byte  (s1_first_reg),
        .crc_next    (crc_next)
    );

    crc32b_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (out_ctl),
        .crc_in    (crc_next),
        .final_xor (final_xor_reg),
        .room      (out_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .crc_value (crc_value)
    );

    a_rise_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_go && s1_last_reg))
        else $error("output beat without a last byte");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !(s1_go && s1_last_reg) |=> !out_valid)
        else $error("output beat repeated");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted beat lost");

endmodule
